### hw/rtl/restore_key_bank_switch_controller_defines.svh
// assertion macros for the restore key bank switch controller
`ifndef RESTORE_KEY_BANK_SWITCH_CONTROLLER_DEFINES_SVH
`define RESTORE_KEY_BANK_SWITCH_CONTROLLER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define RKBS_ASSERT_ALWAYS(name, clk_s, rstn_s, cond) \
    name: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (cond)) \
        else $error("rkbs assertion failed");

// consequent must hold in the same cycle as the antecedent
`define RKBS_ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("rkbs assertion failed");

// consequent must hold in the cycle after the antecedent
`define RKBS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("rkbs assertion failed");

`endif

### hw/rtl/rkbs_pkg.sv
// shared types and constants of the restore key bank switch controller
`default_nettype none

package rkbs_pkg;

    localparam int HOLD_W   = 12;
    localparam int SINCE_W  = 13;
    localparam int PULSE_W  = 8;
    localparam int PHASE_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [HOLD_W-1:0]  HOLD_MAX  = 12'd4095;
    localparam logic [SINCE_W-1:0] SINCE_MAX = 13'd8191;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_RESET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE_END = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SWITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_SHOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BANK = 3'd6;

    // register reset values
    localparam logic [HOLD_W-1:0]  HOLD_RESET_DEFAULT   = 12'd800;
    localparam logic [HOLD_W-1:0]  ANNOUNCE_END_DEFAULT = 12'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_SWITCH_DEFAULT  = 12'd2000;
    localparam logic [SINCE_W-1:0] REPEAT_DEFAULT       = 13'd1000;
    localparam logic [SINCE_W-1:0] IDLE_SHOW_DEFAULT    = 13'd6000;
    localparam logic [PULSE_W-1:0] RESET_PULSE_DEFAULT  = 8'd150;
    localparam logic               INITIAL_BANK_DEFAULT = 1'b0;

    // led modes
    localparam logic [MODE_W-1:0] LED_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] LED_BLUE    = 3'd1;
    localparam logic [MODE_W-1:0] LED_RED     = 3'd2;
    localparam logic [MODE_W-1:0] LED_WHITE   = 3'd3;
    localparam logic [MODE_W-1:0] LED_RAINBOW = 3'd4;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_reset_ms;
        logic [HOLD_W-1:0]  announce_end_ms;
        logic [HOLD_W-1:0]  hold_switch_ms;
        logic [SINCE_W-1:0] repeat_ms;
        logic [SINCE_W-1:0] idle_show_ms;
        logic [PULSE_W-1:0] reset_pulse_ms;
    } cfg_t;

    typedef struct packed {
        logic               bank_high;
        logic               reset_active;
        logic [MODE_W-1:0]  led_mode;
        logic [PHASE_W-1:0] rainbow_phase;
        logic               save_bank;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/rkbs_cfg.sv
// configuration register file
`default_nettype none

module rkbs_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rkbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rkbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rkbs_pkg::cfg_t                       cfg
);
    import rkbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_RESET:   cfg_next.hold_reset_ms   = cfg_wdata[HOLD_W-1:0];
                REG_ANNOUNCE_END: cfg_next.announce_end_ms = cfg_wdata[HOLD_W-1:0];
                REG_HOLD_SWITCH:  cfg_next.hold_switch_ms  = cfg_wdata[HOLD_W-1:0];
                REG_REPEAT:       cfg_next.repeat_ms       = cfg_wdata[SINCE_W-1:0];
                REG_IDLE_SHOW:    cfg_next.idle_show_ms    = cfg_wdata[SINCE_W-1:0];
                REG_RESET_PULSE:  cfg_next.reset_pulse_ms  = cfg_wdata[PULSE_W-1:0];
                // the bank is only loaded at power up, where the default is restored
                REG_INITIAL_BANK: cfg_next = cfg_reg;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_reset_ms   <= HOLD_RESET_DEFAULT;
            cfg_reg.announce_end_ms <= ANNOUNCE_END_DEFAULT;
            cfg_reg.hold_switch_ms  <= HOLD_SWITCH_DEFAULT;
            cfg_reg.repeat_ms       <= REPEAT_DEFAULT;
            cfg_reg.idle_show_ms    <= IDLE_SHOW_DEFAULT;
            cfg_reg.reset_pulse_ms  <= RESET_PULSE_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/rkbs_core.sv
// per-tick state update: hold counting, bank toggle, reset pulse, led mode, rainbow phase
`default_nettype none

module rkbs_core #(
    parameter int RAINBOW_TICKS = 10
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire logic      key_pressed,
    input  wire rkbs_pkg::cfg_t cfg,
    output rkbs_pkg::result_t result
);
    import rkbs_pkg::*;

    localparam logic [PHASE_W-1:0] DIV_LIMIT = PHASE_W'(RAINBOW_TICKS);

    logic               bank_reg, bank_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next, hold_inc;
    logic [SINCE_W-1:0] since_reg, since_next, since_inc;
    logic               pending_reg, pending_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next, pulse_start;
    logic               dark_reg, dark_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] div_reg, div_next, div_inc;
    logic               announce;
    logic               save;
    logic               rst_out;
    logic [MODE_W-1:0]  mode;

    always_comb
    begin
        since_inc = (since_reg != SINCE_MAX) ? since_reg + 1'b1 : since_reg;
        hold_inc  = (hold_reg != HOLD_MAX) ? hold_reg + 1'b1 : hold_reg;

        bank_next    = bank_reg;
        hold_next    = hold_reg;
        since_next   = since_inc;
        pending_next = pending_reg;
        pulse_start  = pulse_reg;
        dark_next    = dark_reg;
        announce     = 1'b0;
        save         = 1'b0;

        if (key_pressed)
        begin
            hold_next = hold_inc;
            if (hold_inc > cfg.hold_reset_ms)
            begin
                if (hold_inc < cfg.announce_end_ms)
                    announce = 1'b1;
                else
                    dark_next = 1'b1;
            end
            if (hold_inc > cfg.hold_switch_ms && since_inc > cfg.repeat_ms)
            begin
                bank_next    = ~bank_reg;
                since_next   = '0;
                save         = 1'b1;
                pending_next = 1'b1;
                dark_next    = 1'b0;
            end
        end
        else
        begin
            hold_next = '0;
            // release after a long hold or after a toggle starts the pulse
            if (pending_reg || hold_reg > cfg.hold_reset_ms)
            begin
                pending_next = 1'b0;
                pulse_start  = cfg.reset_pulse_ms;
                since_next   = '0;
                dark_next    = 1'b0;
            end
        end

        rst_out    = (pulse_start != '0);
        pulse_next = rst_out ? pulse_start - 1'b1 : pulse_start;

        if (rst_out || announce)
            mode = LED_WHITE;
        else if (since_next > cfg.idle_show_ms)
            mode = LED_RAINBOW;
        else if (dark_next)
            mode = LED_OFF;
        else if (bank_next)
            mode = LED_RED;
        else
            mode = LED_BLUE;

        div_inc    = div_reg + 1'b1;
        div_next   = div_reg;
        phase_next = phase_reg;
        if (mode == LED_RAINBOW)
        begin
            if (div_inc >= DIV_LIMIT)
            begin
                div_next   = '0;
                phase_next = phase_reg + 1'b1;
            end
            else
            begin
                div_next = div_inc;
            end
        end

        result.bank_high     = bank_next;
        result.reset_active  = rst_out;
        result.led_mode      = mode;
        result.rainbow_phase = phase_next;
        result.save_bank     = save;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= INITIAL_BANK_DEFAULT;
            hold_reg    <= '0;
            since_reg   <= '0;
            pending_reg <= 1'b0;
            pulse_reg   <= RESET_PULSE_DEFAULT;
            dark_reg    <= 1'b0;
            phase_reg   <= '0;
            div_reg     <= '0;
        end
        else if (accept)
        begin
            bank_reg    <= bank_next;
            hold_reg    <= hold_next;
            since_reg   <= since_next;
            pending_reg <= pending_next;
            pulse_reg   <= pulse_next;
            dark_reg    <= dark_next;
            phase_reg   <= phase_next;
            div_reg     <= div_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/restore_key_bank_switch_controller.sv
// restore key bank switch controller, top level
//
// One key sample per millisecond tick enters on the input channel
// (in_valid / in_ready, payload key_pressed). Each sample gives exactly one
// result on the output channel (out_valid / out_ready, payload bank_high,
// reset_active, led_mode, rainbow_phase, save_bank).
// A sample transferred at one edge shows its result at the output register
// from the next cycle on. Throughput is one sample per cycle while the
// receiver does not stall; the state update and the result register are
// the only stages. While the receiver stalls, the result register holds
// and in_ready stays high only in the cycle the waiting result is taken,
// so no result is lost. Reset clears the tick state, loads the register
// defaults and starts a power-on reset pulse of the default length on the
// first ticks. Registers are written through cfg_we / cfg_index /
// cfg_wdata, by the user only while no sample is in flight (unchecked).
`default_nettype none

`include "restore_key_bank_switch_controller_defines.svh"

module restore_key_bank_switch_controller #(
    parameter int RAINBOW_TICKS = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            key_pressed,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 bank_high,
    output logic                                 reset_active,
    output logic [rkbs_pkg::MODE_W-1:0]          led_mode,
    output logic [rkbs_pkg::PHASE_W-1:0]         rainbow_phase,
    output logic                                 save_bank,
    input  wire logic                            cfg_we,
    input  wire logic [rkbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rkbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rkbs_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    rkbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rkbs_core #(
        .RAINBOW_TICKS (RAINBOW_TICKS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .key_pressed (key_pressed),
        .cfg         (cfg),
        .result      (result)
    );

    // take a new sample whenever the result register is empty or drains now
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign bank_high     = result_reg.bank_high;
    assign reset_active  = result_reg.reset_active;
    assign led_mode      = result_reg.led_mode;
    assign rainbow_phase = result_reg.rainbow_phase;
    assign save_bank     = result_reg.save_bank;

    `RKBS_ASSERT_IMPLIES(a_pulse_is_white, clk, rst_n, out_valid && reset_active, led_mode == LED_WHITE)
    `RKBS_ASSERT_IMPLIES(a_toggle_not_dark, clk, rst_n, out_valid && save_bank, led_mode != LED_OFF)
    `RKBS_ASSERT_NEXT(a_transfer_fills, clk, rst_n, in_valid && in_ready, out_valid)
    `RKBS_ASSERT_ALWAYS(a_no_accept_on_stall, clk, rst_n, !(out_valid && !out_ready && in_ready))

endmodule

`default_nettype wire
